>>> rtl/turing_machine_step_unit_macros.svh
// ---------------------------------------------------------------------------
// turing_machine_step_unit assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef TURING_MACHINE_STEP_UNIT_MACROS_SVH
`define TURING_MACHINE_STEP_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TMSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmsu assertion failed");
// next-cycle implication
`define TMSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmsu assertion failed");
`else
`define TMSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TMSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/tmsu_pkg.sv
// ---------------------------------------------------------------------------
// tmsu_pkg
// sizes, codes and controller/datapath interface types of the step unit
// ---------------------------------------------------------------------------
package tmsu_pkg;

  localparam int STATES     = 64;
  localparam int TAPE_CELLS = 1024;

  localparam int STATE_W    = 6;
  localparam int HEAD_W     = 10;
  localparam int RULE_W     = 9;
  localparam int RULE_DEPTH = 2 * STATES;
  localparam int RULE_AW    = $clog2(RULE_DEPTH);
  localparam int TAPE_AW    = $clog2(TAPE_CELLS);

  localparam logic [HEAD_W-1:0] HEAD_START_RST = 10'd512;

  typedef enum logic [2:0] {
    FN_LOAD    = 3'd0,
    FN_WRITE   = 3'd1,
    FN_STEP    = 3'd2,
    FN_READ    = 3'd3,
    FN_RESTART = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    MV_LEFT  = 2'd0,
    MV_RIGHT = 2'd1,
    MV_HALT  = 2'd2
  } move_t;

  typedef enum logic [1:0] {
    SS_RUNNING = 2'd0,
    SS_HALTED  = 2'd1,
    SS_FAULT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RULE,
    ST_APPLY,
    ST_SHOW,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic clr;       // clearing pass write
    logic latch;     // capture request fields
    logic exec;      // apply request function
    logic rule_rd;   // look up rule for cell under head
    logic apply;     // write cell, move head
    logic show;      // read shown cell
    logic out_load;  // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;  // last cell of clearing pass
    logic step_go;   // latched request is a step that runs
  } dp_stat_t;

endpackage

>>> rtl/tmsu_ram.sv
// ---------------------------------------------------------------------------
// tmsu_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module tmsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tmsu_ctrl.sv
// ---------------------------------------------------------------------------
// tmsu_ctrl
// sequencer of the step unit: clearing pass, request phases, handshakes
// ---------------------------------------------------------------------------
`include "turing_machine_step_unit_macros.svh"

module tmsu_ctrl import tmsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.step_go ? ST_RULE : ST_SHOW;
      end
      ST_RULE: begin
        cmd.rule_rd = 1'b1;
        state_nxt   = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        cmd.show  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  `TMSU_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `TMSU_ASSERT_NXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == ST_EXEC)
  `TMSU_ASSERT_NXT(a_rule_apply, clk, rst_n, state_r == ST_RULE, state_r == ST_APPLY)
  `TMSU_ASSERT_IMP(a_rose_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_DONE)

endmodule

>>> rtl/tmsu_dpath.sv
// ---------------------------------------------------------------------------
// tmsu_dpath
// machine registers, rule table, tape store and result register
// ---------------------------------------------------------------------------
module tmsu_dpath import tmsu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_wr_en,
  input  logic [HEAD_W-1:0]  cfg_wr_data,
  input  logic [2:0]         in_func,
  input  logic [STATE_W-1:0] in_rule_state,
  input  logic               in_rule_symbol,
  input  logic               in_rule_write,
  input  logic [1:0]         in_rule_move,
  input  logic [STATE_W-1:0] in_rule_next,
  input  logic [HEAD_W-1:0]  in_cell_index,
  input  logic               in_cell_symbol,
  output logic [1:0]         out_status,
  output logic               out_read_symbol,
  output logic [HEAD_W-1:0]  out_head_at,
  output logic [STATE_W-1:0] out_current_state
);

  // latched request
  logic [2:0]         func_r;
  logic [STATE_W-1:0] rstate_r;
  logic               rsym_r;
  logic               rwrite_r;
  logic [1:0]         rmove_r;
  logic [STATE_W-1:0] rnext_r;
  logic [HEAD_W-1:0]  cidx_r;
  logic               csym_r;

  // machine state
  logic [HEAD_W-1:0]  head_start_r;
  logic [HEAD_W-1:0]  head_r, head_nxt;
  logic [STATE_W-1:0] mstate_r, mstate_nxt;
  logic               halted_r, halted_nxt;
  logic               fault_r, fault_nxt;
  logic [TAPE_AW-1:0] clr_cnt_r;
  logic [RULE_DEPTH-1:0] rule_vld_r;
  logic               vld_rd_r;
  logic               show_ok_r;

  // result register
  logic [1:0]         res_status_r;
  logic               res_sym_r;
  logic [HEAD_W-1:0]  res_head_r;
  logic [STATE_W-1:0] res_state_r;

  // memory ports
  logic               tape_we, tape_re, tape_rdata, tape_wdata;
  logic [TAPE_AW-1:0] tape_waddr, tape_raddr;
  logic               rule_we, rule_re;
  logic [RULE_AW-1:0] rule_waddr, rule_raddr;
  logic [RULE_W-1:0]  rule_wdata, rule_rdata, rule_eff;

  logic head_ok, state_ok, cidx_ok, rstate_ok;
  logic [TAPE_AW-1:0] show_addr;
  logic               show_ok;

  assign head_ok   = 32'(head_r) < TAPE_CELLS;
  assign state_ok  = 32'(mstate_r) < STATES;
  assign cidx_ok   = 32'(cidx_r) < TAPE_CELLS;
  assign rstate_ok = 32'(rstate_r) < STATES;

  assign stat = '{
    clr_last: clr_cnt_r == TAPE_AW'(TAPE_CELLS - 1),
    step_go:  (func_r == FN_STEP) && !halted_r && !fault_r && head_ok && state_ok
  };

  assign show_addr = (func_r == FN_READ) ? TAPE_AW'(cidx_r) : TAPE_AW'(head_r);
  assign show_ok   = (func_r == FN_READ) ? cidx_ok : head_ok;

  assign rule_eff = vld_rd_r ? rule_rdata : '0;

  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = TAPE_AW'(head_r);
    tape_wdata = rule_eff[0];
    if (cmd.clr) begin
      tape_we    = 1'b1;
      tape_waddr = clr_cnt_r;
      tape_wdata = 1'b0;
    end else if (cmd.exec && func_r == FN_WRITE && cidx_ok) begin
      tape_we    = 1'b1;
      tape_waddr = TAPE_AW'(cidx_r);
      tape_wdata = csym_r;
    end else if (cmd.apply) begin
      tape_we    = 1'b1;
    end
  end

  assign tape_re    = (cmd.exec && stat.step_go) || cmd.show;
  assign tape_raddr = cmd.show ? show_addr : TAPE_AW'(head_r);

  assign rule_we    = cmd.exec && func_r == FN_LOAD && rstate_ok;
  assign rule_waddr = RULE_AW'({rstate_r, rsym_r});
  assign rule_wdata = {rnext_r, rmove_r, rwrite_r};
  assign rule_re    = cmd.rule_rd;
  assign rule_raddr = RULE_AW'({mstate_r, tape_rdata});

  tmsu_ram #(.WIDTH(1), .DEPTH(TAPE_CELLS)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (tape_re),
    .raddr (tape_raddr),
    .rdata (tape_rdata)
  );

  tmsu_ram #(.WIDTH(RULE_W), .DEPTH(RULE_DEPTH)) u_rules (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_waddr),
    .wdata (rule_wdata),
    .re    (rule_re),
    .raddr (rule_raddr),
    .rdata (rule_rdata)
  );

  always_comb begin
    head_nxt   = head_r;
    mstate_nxt = mstate_r;
    halted_nxt = halted_r;
    fault_nxt  = fault_r;
    if (cmd.exec) begin
      if (func_r == FN_RESTART) begin
        head_nxt   = head_start_r;
        mstate_nxt = '0;
        halted_nxt = 1'b0;
        fault_nxt  = 1'b0;
      end else if (func_r == FN_STEP && !halted_r && !fault_r && !(head_ok && state_ok)) begin
        fault_nxt = 1'b1;
      end
    end
    if (cmd.apply) begin
      case (rule_eff[2:1])
        MV_HALT: begin
          halted_nxt = 1'b1;
        end
        MV_LEFT: begin
          if (head_r == '0) begin
            fault_nxt = 1'b1;
          end else begin
            head_nxt   = head_r - HEAD_W'(1);
            mstate_nxt = rule_eff[8:3];
          end
        end
        MV_RIGHT: begin
          if (32'(head_r) == TAPE_CELLS - 1) begin
            fault_nxt = 1'b1;
          end else begin
            head_nxt   = head_r + HEAD_W'(1);
            mstate_nxt = rule_eff[8:3];
          end
        end
        default: begin
          // move code three: stay put, take next state
          mstate_nxt = rule_eff[8:3];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_start_r <= HEAD_START_RST;
      head_r       <= HEAD_START_RST;
      mstate_r     <= '0;
      halted_r     <= 1'b0;
      fault_r      <= 1'b0;
      clr_cnt_r    <= '0;
      rule_vld_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        head_start_r <= cfg_wr_data;
      end
      head_r   <= head_nxt;
      mstate_r <= mstate_nxt;
      halted_r <= halted_nxt;
      fault_r  <= fault_nxt;
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + TAPE_AW'(1);
      end
      if (rule_we) begin
        rule_vld_r[rule_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r   <= in_func;
      rstate_r <= in_rule_state;
      rsym_r   <= in_rule_symbol;
      rwrite_r <= in_rule_write;
      rmove_r  <= in_rule_move;
      rnext_r  <= in_rule_next;
      cidx_r   <= in_cell_index;
      csym_r   <= in_cell_symbol;
    end
    if (cmd.rule_rd) begin
      vld_rd_r <= rule_vld_r[rule_raddr];
    end
    if (cmd.show) begin
      show_ok_r <= show_ok;
    end
    if (cmd.out_load) begin
      res_status_r <= fault_r ? SS_FAULT : (halted_r ? SS_HALTED : SS_RUNNING);
      res_sym_r    <= show_ok_r & tape_rdata;
      res_head_r   <= head_r;
      res_state_r  <= mstate_r;
    end
  end

  assign out_status        = res_status_r;
  assign out_read_symbol   = res_sym_r;
  assign out_head_at       = res_head_r;
  assign out_current_state = res_state_r;

endmodule

>>> rtl/turing_machine_step_unit.sv
// ---------------------------------------------------------------------------
// turing_machine_step_unit
// two-symbol turing machine with a fixed tape, one result per request
// ---------------------------------------------------------------------------
// sequence: a request is taken only in idle, and in_ready stays low until its
//   result is loaded; the registered reads of the tape and rule rams set the
//   phases: a step that runs reads the cell, then its rule, writes the cell
//   and reads the shown cell
// reset: synchronous active-low rst_n, then a clearing pass over all 1024 cells of the
//   tape during which in_ready stays low; cfg writes are taken at any time
// ---------------------------------------------------------------------------
module turing_machine_step_unit import tmsu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: head start cell
  input  logic               cfg_wr_en,
  input  logic [HEAD_W-1:0]  cfg_wr_data,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [STATE_W-1:0] in_rule_state,
  input  logic               in_rule_symbol,
  input  logic               in_rule_write,
  input  logic [1:0]         in_rule_move,
  input  logic [STATE_W-1:0] in_rule_next,
  input  logic [HEAD_W-1:0]  in_cell_index,
  input  logic               in_cell_symbol,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_read_symbol,
  output logic [HEAD_W-1:0]  out_head_at,
  output logic [STATE_W-1:0] out_current_state
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: clear pass, then exec / rule lookup / apply / show / done per
  // request, lookup and apply only for a step that runs; the result register
  // lets a new request in while the previous result still waits on out_ready
  tmsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: head, state and flags, rule ram with per-entry valid bits
  // (entries never loaded read as zero), tape ram, result register
  tmsu_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_func           (in_func),
    .in_rule_state     (in_rule_state),
    .in_rule_symbol    (in_rule_symbol),
    .in_rule_write     (in_rule_write),
    .in_rule_move      (in_rule_move),
    .in_rule_next      (in_rule_next),
    .in_cell_index     (in_cell_index),
    .in_cell_symbol    (in_cell_symbol),
    .out_status        (out_status),
    .out_read_symbol   (out_read_symbol),
    .out_head_at       (out_head_at),
    .out_current_state (out_current_state)
  );

endmodule
